### hw/rtl/fpac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpac_pkg: shared types for the frame parser
// Parse phases, the result item record and byte-wide constants.
// ----------------------------------------------------------------------------
package fpac_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned FlagW = 16;
  localparam logic [ByteW-1:0] ByteMask = 8'hFF;

  // parse phase of the receive stream
  typedef enum logic [2:0] {
    PH_FLAG_HI = 3'd0,
    PH_FLAG_LO = 3'd1,
    PH_PDU     = 3'd2,
    PH_LEN     = 3'd3,
    PH_DATA    = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  // result item kinds
  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_t;

  // one result item
  typedef struct packed {
    kind_t            kind;
    logic [FlagW-1:0] frame_flag;
    logic [ByteW-1:0] frame_pdu;
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] byte_index;
    logic             check_ok;
    logic [ByteW-1:0] received_check;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/fpac_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpac_parser: frame header, payload and check byte parser
// Updates the parse state for every accepted byte and forms the result item
// that the byte causes, if any.
// ----------------------------------------------------------------------------
module fpac_parser (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    take,
  input  wire logic [7:0]              rx_byte,
  input  wire logic                    frame_start,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_check_enable,
  output logic                         res_valid,
  output fpac_pkg::result_t            res
);

  fpac_pkg::phase_t phase_r, phase_nxt, ph_eff;
  logic [15:0] flag_r, flag_nxt;
  logic [7:0]  pdu_r, pdu_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        chk_en_r;
  logic [7:0]  sum_add;

  // hold the check enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_en_r <= 1'b1;
    end else if (cfg_we) begin
      chk_en_r <= cfg_check_enable;
    end
  end

  // advance the parse state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fpac_pkg::PH_FLAG_HI;
      flag_r  <= '0;
      pdu_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      pdu_r   <= pdu_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign sum_add = sum_r + rx_byte;

  // pick the effective phase: a start marker or an unused code restarts
  always_comb begin
    ph_eff = phase_r;
    if (frame_start || !(phase_r inside {fpac_pkg::PH_FLAG_HI, fpac_pkg::PH_FLAG_LO,
                                         fpac_pkg::PH_PDU, fpac_pkg::PH_LEN,
                                         fpac_pkg::PH_DATA, fpac_pkg::PH_CHECK})) begin
      ph_eff = fpac_pkg::PH_FLAG_HI;
    end
  end

  // next state and result item
  always_comb begin
    phase_nxt = phase_r;
    flag_nxt  = flag_r;
    pdu_nxt   = pdu_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    res_valid = 1'b0;
    res.kind           = fpac_pkg::KIND_PAYLOAD;
    res.frame_flag     = flag_r;
    res.frame_pdu      = pdu_r;
    res.frame_length   = len_r;
    res.payload_byte   = '0;
    res.byte_index     = '0;
    res.check_ok       = 1'b0;
    res.received_check = '0;
    case (ph_eff)
      fpac_pkg::PH_FLAG_LO: begin
        flag_nxt  = {flag_r[15:8], rx_byte};
        sum_nxt   = sum_add;
        phase_nxt = fpac_pkg::PH_PDU;
      end
      fpac_pkg::PH_PDU: begin
        pdu_nxt   = rx_byte;
        sum_nxt   = sum_add;
        phase_nxt = fpac_pkg::PH_LEN;
      end
      fpac_pkg::PH_LEN: begin
        len_nxt   = rx_byte;
        sum_nxt   = sum_add;
        cnt_nxt   = '0;
        phase_nxt = (rx_byte == '0) ? fpac_pkg::PH_CHECK : fpac_pkg::PH_DATA;
      end
      fpac_pkg::PH_DATA: begin
        res_valid        = take;
        res.payload_byte = rx_byte;
        res.byte_index   = cnt_r;
        sum_nxt          = sum_add;
        cnt_nxt          = (cnt_r + 8'd1) & fpac_pkg::ByteMask;
        if (cnt_nxt == len_r) begin
          phase_nxt = fpac_pkg::PH_CHECK;
        end
      end
      fpac_pkg::PH_CHECK: begin
        res_valid          = take;
        res.kind           = fpac_pkg::KIND_FRAME_END;
        res.check_ok       = !chk_en_r || (sum_r == rx_byte);
        res.received_check = rx_byte;
        phase_nxt          = fpac_pkg::PH_FLAG_HI;
      end
      default: begin
        // flag high byte opens a new frame
        flag_nxt  = {rx_byte, 8'h00};
        sum_nxt   = rx_byte;
        phase_nxt = fpac_pkg::PH_FLAG_LO;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/fpac_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpac_out_queue: result register with skid stage
// Holds result items for the consumer; the skid entry lets one more item
// in while the head item waits.
// ----------------------------------------------------------------------------
module fpac_out_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire fpac_pkg::result_t       push_data,
  output logic                         space,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output fpac_pkg::result_t            out_data
);

  logic              head_vld_r, head_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  fpac_pkg::result_t head_r, skid_r;
  logic              pop;
  logic              to_skid;

  assign pop       = head_vld_r && out_ready;
  assign to_skid   = push && head_vld_r && !out_ready;
  assign space     = !skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

  // occupancy
  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (pop) begin
      head_vld_nxt = skid_vld_r || push;
      skid_vld_nxt = 1'b0;
    end else if (to_skid) begin
      skid_vld_nxt = 1'b1;
    end else if (push) begin
      head_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // load head from skid first, else from the new item
  always_ff @(posedge clk) begin
    if (pop && skid_vld_r) begin
      head_r <= skid_r;
    end else if (push && (pop || !head_vld_r)) begin
      head_r <= push_data;
    end
    if (to_skid) begin
      skid_r <= push_data;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/frame_parser_additive_checksum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_parser_additive_checksum: length-prefixed frame parser
// Parses flag, PDU, length, payload and check byte; passes payload bytes out
// and ends each frame with a header plus additive checksum verdict.
// ----------------------------------------------------------------------------
//   channel | ports          | direction | carries
//   in      | in_valid/ready | input     | rx_byte, frame_start
//   out     | out_valid/ready| output    | one result item per payload/check
//   cfg     | cfg_valid/ready| input     | check_enable in cfg_data
//
// One byte is accepted per cycle while in_ready is high; its result item is
// registered in the queue head, or in the skid entry while the head waits.
// Reset clears the parse state to "expect flag high byte" and sets check
// enable. A stalled consumer is absorbed by one skid entry; input stalls
// only once both the head and skid entries are full.
// ----------------------------------------------------------------------------
module frame_parser_additive_checksum (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [15:0]      out_frame_flag,
  output logic [7:0]       out_frame_pdu,
  output logic [7:0]       out_frame_length,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_byte_index,
  output logic             out_check_ok,
  output logic [7:0]       out_received_check,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  logic              take;
  logic              space;
  logic              res_valid;
  fpac_pkg::result_t res;
  fpac_pkg::result_t out_data;

  assign in_ready  = space;
  assign take      = in_valid && space;
  assign cfg_ready = 1'b1;

  fpac_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .rx_byte          (in_rx_byte),
    .frame_start      (in_frame_start),
    .cfg_we           (cfg_valid),
    .cfg_check_enable (cfg_data),
    .res_valid        (res_valid),
    .res              (res)
  );

  fpac_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // unpack the result item onto its ports
  assign out_kind           = out_data.kind;
  assign out_frame_flag     = out_data.frame_flag;
  assign out_frame_pdu      = out_data.frame_pdu;
  assign out_frame_length   = out_data.frame_length;
  assign out_payload_byte   = out_data.payload_byte;
  assign out_byte_index     = out_data.byte_index;
  assign out_check_ok       = out_data.check_ok;
  assign out_received_check = out_data.received_check;

endmodule
`default_nettype wire
